FILE: rtl/rcmp_pkg.sv
// ----------------------------------------------------------------------------
// rcmp_pkg
// shared constants and types for the run-compressed mapping page
// ----------------------------------------------------------------------------
package rcmp_pkg;

  localparam int ENTRIES_DEF  = 1024;
  localparam int PPA_BITS_DEF = 32;
  localparam int IDX_W        = 10;
  localparam int DATA_W       = 32;
  localparam int CNT_W        = 11;

  typedef enum logic [1:0] {
    MODE_LOAD   = 2'd0,
    MODE_UPDATE = 2'd1,
    MODE_LOOKUP = 2'd2
  } mode_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RD,
    ST_WAIT,
    ST_STEP,
    ST_OUT
  } state_t;

endpackage

FILE: rtl/run_compressed_mapping_page_unit.sv
// ----------------------------------------------------------------------------
// run_compressed_mapping_page_unit
// one translation page of mappings kept as flat entries, not a run-start bitmap plus head list
// ----------------------------------------------------------------------------
// The page is stored one address per entry in a ram; every change keeps the
// canonical run count up to date. Input transactions on in_* carry mode,
// entry_index and new_ppa; each yields one result on out_* with mapped_ppa,
// run_count and status. Update and in-order load re-count runs by stepping
// through the whole page once, each entry in a ST_WAIT state and then a
// ST_STEP state through a shared compare unit, before the result in ST_OUT.
// Lookup passes ST_RD, ST_WAIT and ST_OUT; rejected or undefined items go
// from ST_RD straight to ST_OUT. The registered ram read port is why each
// read needs the ST_WAIT state. After reset a clearing pass writes the
// unmapped marker into every entry, during which in_tready is low. The
// result is held in an output register until out_tready; no new item is
// taken until it leaves, so a receiver stall lengthens the item by as long
// as the stall lasts.
// ----------------------------------------------------------------------------
module run_compressed_mapping_page_unit #(
  parameter int ENTRIES  = rcmp_pkg::ENTRIES_DEF,
  parameter int PPA_BITS = rcmp_pkg::PPA_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // mode[1:0], entry_index[11:2], new_ppa[43:12]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata   // mapped_ppa[31:0], run_count[42:32], status[43]
);

  localparam int AW = $clog2(ENTRIES);
  localparam int CW = $clog2(ENTRIES + 1);
  localparam logic [PPA_BITS-1:0] UNM = {PPA_BITS{1'b1}};

  rcmp_pkg::state_t state_r, state_nxt;
  logic [AW-1:0]       ptr_r, ptr_nxt;
  logic [AW:0]         load_r, load_nxt;
  logic [CW-1:0]       cnt_r, cnt_nxt, acc_r, acc_nxt;
  logic [PPA_BITS-1:0] prev_r, prev_nxt;
  logic [1:0]          mode_r;
  logic [rcmp_pkg::IDX_W-1:0] idx_r;
  logic [PPA_BITS-1:0] ppa_r;
  logic [31:0]         res_ppa_r, res_ppa_nxt;
  logic                res_st_r, res_st_nxt;
  logic                we;
  logic [AW-1:0]       addr;
  logic [PPA_BITS-1:0] wdata, rdata;
  logic                idx_ok;
  logic [AW-1:0]       idx_a;
  logic [PPA_BITS-1:0] ppa_in;
  logic [63:0]         ppa_ext;

  assign idx_ok  = {22'd0, idx_r} < 32'(ENTRIES);
  assign idx_a   = AW'(idx_r);
  assign ppa_ext = {32'd0, in_tdata[43:12]};
  assign ppa_in  = ppa_ext[PPA_BITS-1:0];

  rcmp_ram #(.WIDTH(PPA_BITS), .DEPTH(ENTRIES)) u_ram (
    .clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rcmp_pkg::ST_CLEAR;
      ptr_r   <= '0;
      load_r  <= '0;
      cnt_r   <= CW'(ENTRIES);
    end else begin
      state_r <= state_nxt;
      ptr_r   <= ptr_nxt;
      load_r  <= load_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r     <= acc_nxt;
    prev_r    <= prev_nxt;
    res_ppa_r <= res_ppa_nxt;
    res_st_r  <= res_st_nxt;
    if (in_tvalid && in_tready) begin
      mode_r <= in_tdata[1:0];
      idx_r  <= in_tdata[11:2];
      ppa_r  <= ppa_in;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      rcmp_pkg::ST_CLEAR: if (ptr_r == AW'(ENTRIES - 1)) state_nxt = rcmp_pkg::ST_IDLE;
      rcmp_pkg::ST_IDLE:  if (in_tvalid) state_nxt = rcmp_pkg::ST_RD;
      rcmp_pkg::ST_RD: begin
        if ((mode_r == rcmp_pkg::MODE_UPDATE || mode_r == rcmp_pkg::MODE_LOOKUP) && idx_ok)
          state_nxt = rcmp_pkg::ST_WAIT;
        else if (mode_r == rcmp_pkg::MODE_LOAD && {22'd0, idx_r} == 32'(load_r))
          state_nxt = rcmp_pkg::ST_WAIT;
        else
          state_nxt = rcmp_pkg::ST_OUT;
      end
      rcmp_pkg::ST_WAIT: begin
        if (mode_r == rcmp_pkg::MODE_LOOKUP) state_nxt = rcmp_pkg::ST_OUT;
        else state_nxt = rcmp_pkg::ST_STEP;
      end
      rcmp_pkg::ST_STEP:  if (ptr_r == AW'(ENTRIES - 1)) state_nxt = rcmp_pkg::ST_OUT;
                          else state_nxt = rcmp_pkg::ST_WAIT;
      rcmp_pkg::ST_OUT:   if (out_tready) state_nxt = rcmp_pkg::ST_IDLE;
      default:            state_nxt = rcmp_pkg::ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    logic starts;
    logic [PPA_BITS-1:0] v;
    logic [CW-1:0] acc_add;
    ptr_nxt     = ptr_r;
    load_nxt    = load_r;
    cnt_nxt     = cnt_r;
    acc_nxt     = acc_r;
    prev_nxt    = prev_r;
    res_ppa_nxt = res_ppa_r;
    res_st_nxt  = res_st_r;
    we          = 1'b0;
    addr        = ptr_r;
    wdata       = UNM;
    in_tready   = (state_r == rcmp_pkg::ST_IDLE);
    out_tvalid  = (state_r == rcmp_pkg::ST_OUT);
    v           = (ptr_r == idx_a) ? ppa_r : rdata;
    starts      = (ptr_r == '0) || (prev_r == UNM) || (v != prev_r + 1'b1);
    acc_add     = acc_r + CW'(starts);
    case (state_r)
      rcmp_pkg::ST_CLEAR: begin
        we = 1'b1;
        ptr_nxt = ptr_r + 1'b1;
      end
      rcmp_pkg::ST_IDLE: begin
        ptr_nxt = '0;
        acc_nxt = '0;
      end
      rcmp_pkg::ST_RD: begin
        res_st_nxt  = 1'b0;
        res_ppa_nxt = '0;
        addr = idx_a;
        if (mode_r == rcmp_pkg::MODE_LOAD) begin
          if ({22'd0, idx_r} != 32'(load_r)) res_st_nxt = 1'b1;
          else addr = '0;
        end else if ((mode_r == rcmp_pkg::MODE_UPDATE || mode_r == rcmp_pkg::MODE_LOOKUP)
                     && !idx_ok) begin
          res_ppa_nxt = 32'(UNM);
        end else if (mode_r == rcmp_pkg::MODE_UPDATE) begin
          addr = '0;
        end
      end
      rcmp_pkg::ST_WAIT: begin
        if (mode_r == rcmp_pkg::MODE_LOOKUP) res_ppa_nxt = 32'(rdata);
      end
      rcmp_pkg::ST_STEP: begin
        if (ptr_r == idx_a && mode_r == rcmp_pkg::MODE_UPDATE)
          res_ppa_nxt = 32'(rdata);
        we       = (ptr_r == idx_a);
        wdata    = ppa_r;
        acc_nxt  = acc_add;
        prev_nxt = v;
        ptr_nxt  = ptr_r + 1'b1;
        addr     = ptr_r;
        if (ptr_r == AW'(ENTRIES - 1)) begin
          cnt_nxt = acc_add;
          ptr_nxt = '0;
          if (mode_r == rcmp_pkg::MODE_LOAD)
            load_nxt = (load_r == (AW+1)'(ENTRIES - 1)) ? '0 : load_r + 1'b1;
        end
      end
      default: ;
    endcase
    out_tdata = {4'd0, res_st_r, 11'(cnt_r), res_ppa_r};
  end

  // read address for the next step entry is presented during ST_WAIT's cycle
  // and the registered ram read returns it in ST_STEP; the step reads the
  // current pointer, so the ram address in ST_WAIT must be ptr_r too

  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !out_tvalid) else $error("ready while result pending");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed under stall");
  a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> cnt_r != '0) else $error("zero run count");

endmodule

FILE: rtl/rcmp_ram.sv
// ----------------------------------------------------------------------------
// rcmp_ram
// generic single-port ram with registered read
// ----------------------------------------------------------------------------
module rcmp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule
